// ----- rtl/smet_pkg.sv -----
// ----------------------------------------------------------------------------
// smet_pkg
// Shared types and constants of the sparse matrix entry table.
// ----------------------------------------------------------------------------
package smet_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int INDEX_BITS    = 16;
  localparam int VALUE_BITS    = 64;

  localparam int SLOT_BITS  = $clog2(TABLE_ENTRIES);
  localparam int COUNT_BITS = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_BITS   = 2 * INDEX_BITS;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_ACT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] row_index;
    logic [15:0] col_index;
    logic [63:0] entry_value;
  } smet_in_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic        hit;
    logic        status;
    logic [6:0]  entry_count;
  } smet_out_t;

  typedef struct packed {
    logic                 set_en;
    logic                 clr_en;
    logic [SLOT_BITS-1:0] slot;
    logic [KEY_BITS-1:0]  key;
  } cam_upd_t;

  typedef struct packed {
    logic                 hit;
    logic                 full;
    logic [SLOT_BITS-1:0] match_slot;
    logic [SLOT_BITS-1:0] free_slot;
  } cam_srch_t;

endpackage

// ----- rtl/smet_ram.sv -----
// ----------------------------------------------------------------------------
// smet_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module smet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/smet_cam.sv -----
// ----------------------------------------------------------------------------
// smet_cam
// Key store with valid marks, a parallel key match and a lowest-free-slot
// search. The search result is registered.
// ----------------------------------------------------------------------------
module smet_cam import smet_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [KEY_BITS-1:0] search_key,
  input  cam_upd_t            upd,
  output cam_srch_t           srch
);

  logic [KEY_BITS-1:0]      key_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [TABLE_ENTRIES-1:0] valid_nxt;
  logic [TABLE_ENTRIES-1:0] match_vec;
  logic [TABLE_ENTRIES-1:0] free_vec;
  logic [TABLE_ENTRIES-1:0] free_oh;
  cam_srch_t                srch_r;
  cam_srch_t                srch_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (upd.set_en) begin
      valid_nxt[upd.slot] = 1'b1;
    end
    if (upd.clr_en) begin
      valid_nxt[upd.slot] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.set_en) begin
      key_r[upd.slot] <= upd.key;
    end
  end

  always_comb begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      match_vec[k] = valid_r[k] && (key_r[k] == search_key);
    end
  end

  assign free_vec = ~valid_r;
  assign free_oh  = free_vec & (~free_vec + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});

  always_comb begin
    srch_nxt.hit        = |match_vec;
    srch_nxt.full       = &valid_r;
    srch_nxt.match_slot = '0;
    srch_nxt.free_slot  = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (match_vec[k]) begin
        srch_nxt.match_slot = srch_nxt.match_slot | SLOT_BITS'(k);
      end
      if (free_oh[k]) begin
        srch_nxt.free_slot = srch_nxt.free_slot | SLOT_BITS'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    srch_r <= srch_nxt;
  end

  assign srch = srch_r;

endmodule

// ----- rtl/sparse_matrix_entry_table.sv -----
// ----------------------------------------------------------------------------
// sparse_matrix_entry_table
// Fixed-capacity associative table of sparse matrix entries keyed by
// (row, column), with insert, delete and lookup operations.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------
//   input    | start / busy       | in_item  (smet_in_t)
//   result   | out_valid strobe   | out_item (smet_out_t)
//
// Each operation runs from the transfer cycle through the result cycle,
// in order: the request is registered, the parallel key match runs, the
// value memory is accessed and the valid marks updated, and the result is
// on the ports. The value memory port and the match register set these
// steps. Reset clears the valid marks and the entry count. Busy stays high
// from the cycle after the transfer until the result cycle ends; the
// result receiver cannot stall the block.
// ----------------------------------------------------------------------------
module sparse_matrix_entry_table import smet_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  smet_in_t  in_item,
  output logic      out_valid,
  output smet_out_t out_item
);

  state_t                state_r;
  state_t                state_nxt;
  smet_in_t              req_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic                  hit_r;
  logic                  status_r;
  logic [KEY_BITS-1:0]   req_key;
  cam_upd_t              upd;
  cam_srch_t             srch;
  logic                  ram_we;
  logic [SLOT_BITS-1:0]  ram_waddr;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic                  do_new;
  logic                  do_del;

  assign req_key = {req_r.row_index[INDEX_BITS-1:0], req_r.col_index[INDEX_BITS-1:0]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: state_nxt = S_ACT;
      S_ACT:   state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      req_r <= in_item;
    end
  end

  assign do_new = (state_r == S_ACT) && (req_r.opcode == OP_INSERT) && !srch.hit
                  && !srch.full;
  assign do_del = (state_r == S_ACT) && (req_r.opcode == OP_DELETE) && srch.hit;

  always_comb begin
    upd.set_en = do_new;
    upd.clr_en = do_del;
    upd.slot   = do_new ? srch.free_slot : srch.match_slot;
    upd.key    = req_key;
  end

  always_comb begin
    ram_we    = (state_r == S_ACT) && (req_r.opcode == OP_INSERT)
                && (srch.hit || !srch.full);
    ram_waddr = srch.hit ? srch.match_slot : srch.free_slot;
  end

  always_comb begin
    count_nxt = count_r;
    if (do_new) begin
      count_nxt = count_r + COUNT_BITS'(1);
    end else if (do_del) begin
      count_nxt = count_r - COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ACT) begin
      hit_r    <= srch.hit && (req_r.opcode != OP_UNUSED);
      status_r <= (req_r.opcode == OP_INSERT) && !srch.hit && srch.full;
    end
  end

  smet_cam u_cam (
    .clk        (clk),
    .rst_n      (rst_n),
    .search_key (req_key),
    .upd        (upd),
    .srch       (srch)
  );

  smet_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_r.entry_value[VALUE_BITS-1:0]),
    .raddr (srch.match_slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_RESP);
    out_item.read_value  = (hit_r && req_r.opcode == OP_LOOKUP) ? 64'(ram_rdata) : 64'd0;
    out_item.hit         = hit_r;
    out_item.status      = status_r;
    out_item.entry_count = 7'(count_r);
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sparse matrix entry table. Insert, delete,
// lookup and unused operations are sent over the start/busy handshake,
// partly with random idle gaps. An in-bench model of the table predicts
// each result, and every result strobe is compared field by field with
// the oldest prediction. Directed tests cover the key and value extremes,
// misses, updates and the full table. A long random run then draws most
// keys from a small pool so hits, deletes and a full table occur often.
// ----------------------------------------------------------------------------
module testbench;
  import smet_pkg::*;

  localparam int STALL_LIMIT = 200;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  smet_in_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  smet_out_t out_item;

  logic [15:0] tbl_row   [TABLE_ENTRIES];
  logic [15:0] tbl_col   [TABLE_ENTRIES];
  logic [63:0] tbl_value [TABLE_ENTRIES];
  bit          tbl_valid [TABLE_ENTRIES];
  int          tbl_count;

  smet_out_t   pending_results[$];
  bit          idle_on;
  int          errors;
  int          stall_cycles;
  int          n_ops;
  int          n_hits;
  int          n_full;
  int          peak_count;
  logic [15:0] pool_row [8];
  logic [15:0] pool_col [12];

  sparse_matrix_entry_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  function automatic smet_out_t apply_table_op(smet_in_t item);
    smet_out_t res;
    int        match;
    int        free_slot;
    res       = '0;
    match     = -1;
    free_slot = -1;
    if (item.opcode != OP_UNUSED) begin
      for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
        if (tbl_valid[k] && tbl_row[k] == item.row_index && tbl_col[k] == item.col_index)
          match = k;
        if (!tbl_valid[k])
          free_slot = k;
      end
      res.hit = (match >= 0);
      case (item.opcode)
        OP_INSERT: begin
          if (match >= 0) begin
            tbl_value[match] = item.entry_value;
          end else if (free_slot < 0) begin
            res.status = 1'b1;
          end else begin
            tbl_row[free_slot]   = item.row_index;
            tbl_col[free_slot]   = item.col_index;
            tbl_value[free_slot] = item.entry_value;
            tbl_valid[free_slot] = 1'b1;
            tbl_count++;
          end
        end
        OP_DELETE: begin
          if (match >= 0) begin
            tbl_valid[match] = 1'b0;
            tbl_count--;
          end
        end
        OP_LOOKUP: begin
          if (match >= 0)
            res.read_value = tbl_value[match];
        end
        default: begin
        end
      endcase
    end
    res.entry_count = 7'(tbl_count);
    return res;
  endfunction

  task automatic send_op(logic [1:0] op, logic [15:0] r, logic [15:0] c, logic [63:0] v);
    smet_in_t  item;
    smet_out_t res;
    int        gap;
    item.opcode      = op;
    item.row_index   = r;
    item.col_index   = c;
    item.entry_value = v;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    res = apply_table_op(item);
    pending_results.push_back(res);
    n_ops++;
    if (res.hit) n_hits++;
    if (res.status) n_full++;
    if (tbl_count > peak_count) peak_count = tbl_count;
  endtask

  function automatic logic [63:0] rand_value();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_basic_ops();
    idle_on = 1'b1;
    send_op(OP_LOOKUP, 16'h0000, 16'h0000, '1);
    send_op(OP_DELETE, 16'hffff, 16'hffff, '0);
    send_op(OP_INSERT, 16'h0000, 16'h0000, 64'h0);
    send_op(OP_INSERT, 16'hffff, 16'hffff, '1);
    send_op(OP_INSERT, 16'h0000, 16'hffff, 64'h5555_5555_5555_5555);
    send_op(OP_INSERT, 16'hffff, 16'h0000, 64'haaaa_aaaa_aaaa_aaaa);
    send_op(OP_LOOKUP, 16'h0000, 16'h0000, '0);
    send_op(OP_LOOKUP, 16'hffff, 16'hffff, '0);
    send_op(OP_LOOKUP, 16'h0000, 16'hffff, '0);
    send_op(OP_LOOKUP, 16'hffff, 16'h0000, '0);
    send_op(OP_INSERT, 16'hffff, 16'hffff, 64'h0123_4567_89ab_cdef);
    send_op(OP_LOOKUP, 16'hffff, 16'hffff, '0);
    send_op(OP_UNUSED, 16'hffff, 16'hffff, '1);
    send_op(OP_DELETE, 16'h0000, 16'h0000, '1);
    send_op(OP_LOOKUP, 16'h0000, 16'h0000, '0);
    send_op(OP_DELETE, 16'h0000, 16'h0000, '0);
    send_op(OP_INSERT, 16'h0000, 16'h0000, '1);
    send_op(OP_LOOKUP, 16'h0000, 16'h0000, '0);
    send_op(OP_LOOKUP, 16'h1234, 16'h5678, '0);
    idle_on = 1'b0;
    send_op(OP_DELETE, 16'hffff, 16'hffff, '0);
    send_op(OP_DELETE, 16'h0000, 16'hffff, '0);
    send_op(OP_DELETE, 16'hffff, 16'h0000, '0);
    send_op(OP_DELETE, 16'h0000, 16'h0000, '0);
  endtask

  task automatic test_full_table();
    idle_on = 1'b0;
    for (int k = 0; k < TABLE_ENTRIES; k++)
      send_op(OP_INSERT, 16'(k * 3), 16'hffff - 16'(k), rand_value());
    idle_on = 1'b1;
    send_op(OP_INSERT, 16'h7777, 16'h7777, rand_value());
    send_op(OP_LOOKUP, 16'h7777, 16'h7777, '0);
    send_op(OP_INSERT, 16'(15), 16'hffff - 16'(5), '1);
    send_op(OP_LOOKUP, 16'(15), 16'hffff - 16'(5), '0);
    send_op(OP_UNUSED, 16'(15), 16'hffff - 16'(5), '0);
    send_op(OP_DELETE, 16'h7777, 16'h7777, '0);
    send_op(OP_DELETE, 16'(30), 16'hffff - 16'(10), '0);
    send_op(OP_INSERT, 16'h7777, 16'h7777, rand_value());
    send_op(OP_INSERT, 16'h8888, 16'h8888, rand_value());
    send_op(OP_LOOKUP, 16'h7777, 16'h7777, '0);
    idle_on = 1'b0;
    send_op(OP_DELETE, 16'h7777, 16'h7777, '0);
    for (int k = 0; k < TABLE_ENTRIES; k++)
      send_op(OP_DELETE, 16'(k * 3), 16'hffff - 16'(k), '0);
  endtask

  task automatic test_random_ops(int n_items);
    logic [1:0]  op;
    logic [15:0] r;
    logic [15:0] c;
    int          pick;
    bit          fill_phase;
    pool_row[0] = 16'h0000;
    pool_row[1] = 16'hffff;
    for (int k = 2; k < 8; k++) pool_row[k] = 16'($urandom());
    pool_col[0] = 16'h0000;
    pool_col[1] = 16'hffff;
    for (int k = 2; k < 12; k++) pool_col[k] = 16'($urandom());
    fill_phase = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        idle_on    = (i % 300 != 0) && ($urandom_range(0, 3) != 0);
        fill_phase = ~fill_phase | (i == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 5)
        op = OP_UNUSED;
      else if (pick < (fill_phase ? 65 : 30))
        op = OP_INSERT;
      else if (pick < (fill_phase ? 80 : 75))
        op = OP_DELETE;
      else
        op = OP_LOOKUP;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        r = pool_row[$urandom_range(0, 7)];
        c = pool_col[$urandom_range(0, 11)];
      end else if (pick < 93) begin
        r = pool_row[$urandom_range(0, 7)];
        c = 16'($urandom());
      end else begin
        r = 16'($urandom());
        c = 16'($urandom());
      end
      send_op(op, r, c, rand_value());
    end
  endtask

  always @(posedge clk) begin : result_check
    smet_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no operation pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.read_value !== want.read_value) begin
          $error("read_value expected %h got %h", want.read_value, out_item.read_value);
          errors++;
        end
        if (out_item.hit !== want.hit) begin
          $error("hit expected %b got %b", want.hit, out_item.hit);
          errors++;
        end
        if (out_item.status !== want.status) begin
          $error("status expected %b got %b", want.status, out_item.status);
          errors++;
        end
        if (out_item.entry_count !== want.entry_count) begin
          $error("entry_count expected %0d got %0d", want.entry_count, out_item.entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < TABLE_ENTRIES; k++) tbl_valid[k] = 1'b0;
    tbl_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_full_table();
    test_random_ops(1000);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Ran %0d operations: %0d found their key, %0d inserts refused by a full table.",
             n_ops, n_hits, n_full);
    $display("Peak occupancy was %0d of %0d slots.", peak_count, TABLE_ENTRIES);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
